// ----- sv/drs_pkg.sv -----
// Shared widths, constants and types of the dosage r-squared estimator.
`timescale 1ns / 1ps
`default_nettype none

package drs_pkg;

   localparam int DOSAGE_W    = 16;
   localparam int FRAC_BITS   = 14;
   localparam int RSQ_W       = 16;
   localparam int COUNT_W     = 17;
   localparam int SUM_W       = 34;
   localparam int SQ_W        = 49;
   localparam int FULL_W      = COUNT_W + FRAC_BITS + 1;
   localparam int MUL_W       = 32;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int NQ_W        = COUNT_W + SQ_W;
   localparam int QUO_W       = RSQ_W - 1;
   localparam int STEP_W      = $clog2(QUO_W + 1);
   localparam int MUL_STEPS   = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [RSQ_W-1:0] RSQ_ONE = RSQ_W'(1) << QUO_W;

   // Totals of one finished marker, handed from the front to the back.
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [SUM_W-1:0]   sum;
      logic [SQ_W-1:0]    sqsum;
   } drs_marker_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIFF,
      ST_DIV,
      ST_OUT
   } drs_state_type;

   typedef struct packed {
      logic deq_ready;
      logic load_out;
   } drs_back_ctrl_type;

endpackage

`default_nettype wire

// ----- sv/drs_front.sv -----
// Front end: accumulates count, sum and sum of squares and closes each marker.
`timescale 1ns / 1ps
`default_nettype none

module drs_front import drs_pkg::*; #(
   parameter int MAX_PEOPLE = 65536
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [DOSAGE_W-1:0] req_dosage,
   input  wire logic                req_last_person,
   output logic                     push_valid,
   input  wire logic                push_ready,
   output drs_marker_type           push_marker
);

   localparam int CW = $clog2(MAX_PEOPLE + 1);
   localparam int SW = CW + DOSAGE_W;
   localparam int QW = CW + 2 * DOSAGE_W;

   logic [CW-1:0]           count_ff, count_in, count_next;
   logic [SW-1:0]           sum_ff, sum_in, sum_next;
   logic [QW-1:0]           sq_ff, sq_in, sq_next;
   logic [2*DOSAGE_W-1:0]   dosage_sq;
   logic                    accept;
   logic                    end_marker;

   assign req_ready = push_ready;
   assign accept    = req_valid & push_ready;

   always_comb begin
      dosage_sq  = req_dosage * req_dosage;
      count_next = count_ff + CW'(1);
      sum_next   = sum_ff + SW'(req_dosage);
      sq_next    = sq_ff + QW'(dosage_sq);
      // A marker also closes when the people count reaches its limit.
      end_marker = req_last_person || (count_next == CW'(MAX_PEOPLE));
   end

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      if (accept) begin
         if (end_marker) begin
            count_in = '0;
            sum_in   = '0;
            sq_in    = '0;
         end else begin
            count_in = count_next;
            sum_in   = sum_next;
            sq_in    = sq_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
      end
   end

   assign push_valid        = req_valid && end_marker;
   assign push_marker.count = COUNT_W'(count_next);
   assign push_marker.sum   = SUM_W'(sum_next);
   assign push_marker.sqsum = SQ_W'(sq_next);

endmodule

`default_nettype wire

// ----- sv/drs_queue.sv -----
// Short queue of finished marker totals between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module drs_queue import drs_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push_valid,
   output logic                push_ready,
   input  wire drs_marker_type push_marker,
   output logic                deq_valid,
   input  wire logic           deq_ready,
   output drs_marker_type      deq_marker
);

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   drs_marker_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                do_push, do_pop;

   assign push_ready = (fill_ff != FILL_W'(QUEUE_DEPTH));
   assign deq_valid  = (fill_ff != '0);
   assign deq_marker = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = deq_valid && deq_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_marker;
      end
   end

endmodule

`default_nettype wire

// ----- sv/drs_back.sv -----
// Back end: products on one shared multiplier, a restoring divider and the result register.
`timescale 1ns / 1ps
`default_nettype none

module drs_back import drs_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             deq_valid,
   output logic                  deq_ready,
   input  wire drs_marker_type   deq_marker,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [RSQ_W-1:0]      rsp_rsq,
   output logic                  rsp_degenerate
);

   drs_state_type       state_ff, state_in;
   drs_back_ctrl_type   ctrl;

   logic [COUNT_W-1:0]  n_ff;
   logic [SQ_W-1:0]     q_ff;
   logic [MUL_W-1:0]    s_ff;
   logic [MUL_W-1:0]    b_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [NQ_W-1:0]     nq_ff;
   logic [PROD_W-1:0]   ss_ff;
   logic [PROD_W-1:0]   den_ff;
   logic [NQ_W-1:0]     rem_ff;
   logic [QUO_W-1:0]    quo_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                sat_ff;
   logic                degen_ff;

   logic                rsp_valid_ff;
   logic [RSQ_W-1:0]    rsp_rsq_ff;
   logic                rsp_degenerate_ff;

   logic [FULL_W-1:0]   head_full;
   logic                head_degen;
   logic [MUL_W-1:0]    mul_a, mul_b;
   logic [NQ_W:0]       dbl_num;
   logic                sat_now;
   logic [PROD_W:0]     div_shift;
   logic [PROD_W:0]     div_diff;
   logic                div_ge;

   // Expected variance is zero or negative when the sum is zero or the mean is 2.0 or more.
   always_comb begin
      head_full  = FULL_W'({deq_marker.count, {(FRAC_BITS + 1){1'b0}}});
      head_degen = (deq_marker.sum == '0) || (deq_marker.sum >= SUM_W'(head_full));
   end

   always_comb begin
      case (step_ff[1:0])
         2'd0: begin
            mul_a = MUL_W'(n_ff);
            mul_b = q_ff[MUL_W-1:0];
         end
         2'd1: begin
            mul_a = MUL_W'(n_ff);
            mul_b = MUL_W'(q_ff[SQ_W-1:MUL_W]);
         end
         2'd2: begin
            mul_a = s_ff;
            mul_b = s_ff;
         end
         default: begin
            mul_a = s_ff;
            mul_b = b_ff;
         end
      endcase
   end

   // The first quotient bit decides saturation: 2*num >= den means a ratio of 1.0 or more.
   always_comb begin
      dbl_num   = {rem_ff, 1'b0};
      sat_now   = dbl_num >= (NQ_W + 1)'(den_ff);
      div_shift = {rem_ff[PROD_W-1:0], 1'b0};
      div_ge    = div_shift >= {1'b0, den_ff};
      div_diff  = div_shift - {1'b0, den_ff};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (deq_valid) begin
               state_in = head_degen ? ST_OUT : ST_MUL;
            end
         end
         ST_MUL: begin
            if (step_ff == STEP_W'(MUL_STEPS)) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (((step_ff == '0) && sat_now) || (step_ff == STEP_W'(QUO_W))) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.deq_ready = 1'b1;
         end
         ST_OUT: begin
            ctrl.load_out = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   assign deq_ready = ctrl.deq_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            n_ff     <= deq_marker.count;
            q_ff     <= deq_marker.sqsum;
            s_ff     <= deq_marker.sum[MUL_W-1:0];
            b_ff     <= MUL_W'(head_full) - deq_marker.sum[MUL_W-1:0];
            degen_ff <= head_degen;
            sat_ff   <= 1'b0;
            quo_ff   <= '0;
            step_ff  <= '0;
         end
         ST_MUL: begin
            prod_ff <= mul_a * mul_b;
            case (step_ff)
               STEP_W'(1): nq_ff  <= NQ_W'(prod_ff);
               STEP_W'(2): nq_ff  <= nq_ff + NQ_W'({prod_ff, {MUL_W{1'b0}}});
               STEP_W'(3): ss_ff  <= prod_ff;
               STEP_W'(4): den_ff <= prod_ff;
               default: begin
               end
            endcase
            step_ff <= step_ff + STEP_W'(1);
         end
         ST_DIFF: begin
            rem_ff  <= nq_ff - NQ_W'(ss_ff);
            step_ff <= '0;
         end
         ST_DIV: begin
            if (step_ff == '0) begin
               if (sat_now) begin
                  sat_ff <= 1'b1;
               end else begin
                  rem_ff <= dbl_num[NQ_W-1:0];
               end
            end else if (div_ge) begin
               rem_ff <= NQ_W'(div_diff);
               quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_ff <= NQ_W'(div_shift);
               quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
            end
            step_ff <= step_ff + STEP_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_out) begin
         rsp_degenerate_ff <= degen_ff;
         if (degen_ff) begin
            rsp_rsq_ff <= '0;
         end else if (sat_ff) begin
            rsp_rsq_ff <= RSQ_ONE;
         end else begin
            rsp_rsq_ff <= RSQ_W'(quo_ff);
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rsq        = rsp_rsq_ff;
   assign rsp_degenerate = rsp_degenerate_ff;

endmodule

`default_nettype wire

// ----- sv/dosage_rsq_estimator.sv -----
// A marker's result word enters the result register after its totals leave the queue;
// a saturating ratio skips the divide steps, a degenerate marker the products and divide.
// Otherwise the back end forms four products on the shared 32x32 multiplier, then runs
// a saturation check and fifteen restoring divide steps. Two closed markers can wait
// between front and back. Throughput: one dosage word per cycle while the queue has room.
// Reset clears the running totals, the queue, the sequencer and the result valid flag.
`timescale 1ns / 1ps
`default_nettype none

module dosage_rsq_estimator import drs_pkg::*; #(
   parameter int MAX_PEOPLE = 65536
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [DOSAGE_W-1:0] req_dosage,
   input  wire logic                req_last_person,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [RSQ_W-1:0]         rsp_rsq,
   output logic                     rsp_degenerate
);

   logic           push_valid, push_ready;
   drs_marker_type push_marker;
   logic           deq_valid, deq_ready;
   drs_marker_type deq_marker;

   drs_front #(
      .MAX_PEOPLE(MAX_PEOPLE)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_dosage     (req_dosage),
      .req_last_person(req_last_person),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_marker    (push_marker)
   );

   drs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_marker(push_marker),
      .deq_valid  (deq_valid),
      .deq_ready  (deq_ready),
      .deq_marker (deq_marker)
   );

   drs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .deq_valid     (deq_valid),
      .deq_ready     (deq_ready),
      .deq_marker    (deq_marker),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rsq       (rsp_rsq),
      .rsp_degenerate(rsp_degenerate)
   );

endmodule

`default_nettype wire
